### hdl/spd_pkg.sv
`timescale 1ns / 1ps

package spd_pkg;

   // Field widths of the sample and index paths
   localparam int SAMPLE_BITS = 16;
   localparam int INDEX_BITS  = 24;
   localparam int ALPHA_BITS  = 16;
   localparam int FRAC_BITS   = 15;

   // Smoothed value: sample units scaled by 2^15, with one guard bit
   localparam int SMOOTH_BITS = SAMPLE_BITS + 16;

   // Unity weight in Q1.15
   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(32768);

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_WIDE_BITS  = (INDEX_BITS > SAMPLE_BITS) ? INDEX_BITS : SAMPLE_BITS;
   localparam int CSR_DATA_BITS  = (CSR_WIDE_BITS > ALPHA_BITS) ? CSR_WIDE_BITS : ALPHA_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ALPHA         = 3'd0,
      CSR_FLOOR         = 3'd1,
      CSR_AMPLITUDE     = 3'd2,
      CSR_MIN_WIDTH     = 3'd3,
      CSR_MAX_WIDTH     = 3'd4
   } csr_index_type;

   // Register reset values
   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET     = ALPHA_BITS'(9830);
   localparam logic [INDEX_BITS-1:0] MAX_WIDTH_RESET = {INDEX_BITS{1'b1}};

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] start_index;
      logic [INDEX_BITS-1:0] end_index;
   } rsp_payload_type;

   typedef struct packed {
      logic [ALPHA_BITS-1:0]         alpha_q15;
      logic signed [SAMPLE_BITS-1:0] floor_level;
      logic [SAMPLE_BITS-1:0]        amplitude_threshold;
      logic [INDEX_BITS-1:0]         min_width;
      logic [INDEX_BITS-1:0]         max_width;
   } cfg_type;

   // Item leaving the smoothing stage
   typedef struct packed {
      logic                          valid;
      logic                          first;
      logic                          last;
      logic signed [SMOOTH_BITS-1:0] value;
   } smooth_type;

endpackage

### hdl/smoothed_pulse_detector_core.sv
`timescale 1ns / 1ps

// Smoothed pulse detector.
// req channel: one signed sample per item, with last marking the end of a
// record. An item is taken at a clock edge where req_valid is high and
// req_stall is low.
// rsp channel: zero or one item per sample, carrying the start and end index
// of a qualified pulse; taken where rsp_valid is high and rsp_stall is low.
// csr channel: register writes by index (alpha, floor, amplitude threshold,
// minimum and maximum width); csr_ready is always high. Write only while idle.
// Throughput: one sample per cycle while no shown result is stalled, set by
// the combinational multiply-add loop of the exponential average. A result
// reaches rsp via the input register, smoothing stage and output register.
// When a result waits and the receiver stalls, req_stall rises and the whole
// pipeline holds; otherwise samples keep flowing while a result is shown.
// Synchronous reset restores the register defaults and empties the pipeline;
// the record state (average, counters, open pulse) returns to zero.
module smoothed_pulse_detector_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  spd_pkg::req_payload_type            req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output spd_pkg::rsp_payload_type            rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [spd_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   spd_pkg::cfg_type    cfg;
   spd_pkg::smooth_type smooth;
   logic                advance;

   // Move every stage unless a shown result is stalled
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   spd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   spd_smooth u_smooth (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_item  (req_item),
      .alpha_q15 (cfg.alpha_q15),
      .smooth    (smooth)
   );

   spd_detect u_detect (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .smooth    (smooth),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

### hdl/spd_csr.sv
`timescale 1ns / 1ps

module spd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [spd_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output spd_pkg::cfg_type                    cfg
);

   spd_pkg::cfg_type cfg_ff;

   // Always take a write; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_q15           <= spd_pkg::ALPHA_RESET;
         cfg_ff.floor_level         <= '0;
         cfg_ff.amplitude_threshold <= '0;
         cfg_ff.min_width           <= '0;
         cfg_ff.max_width           <= spd_pkg::MAX_WIDTH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            spd_pkg::CSR_ALPHA: begin
               cfg_ff.alpha_q15 <= csr_data[spd_pkg::ALPHA_BITS-1:0];
            end
            spd_pkg::CSR_FLOOR: begin
               cfg_ff.floor_level <= $signed(csr_data[spd_pkg::SAMPLE_BITS-1:0]);
            end
            spd_pkg::CSR_AMPLITUDE: begin
               cfg_ff.amplitude_threshold <= csr_data[spd_pkg::SAMPLE_BITS-1:0];
            end
            spd_pkg::CSR_MIN_WIDTH: begin
               cfg_ff.min_width <= csr_data[spd_pkg::INDEX_BITS-1:0];
            end
            spd_pkg::CSR_MAX_WIDTH: begin
               cfg_ff.max_width <= csr_data[spd_pkg::INDEX_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/spd_smooth.sv
`timescale 1ns / 1ps

module spd_smooth (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       req_valid,
   input  spd_pkg::req_payload_type   req_item,
   input  logic [spd_pkg::ALPHA_BITS-1:0] alpha_q15,
   output spd_pkg::smooth_type        smooth
);

   localparam int SW = spd_pkg::SMOOTH_BITS;
   localparam int SB = spd_pkg::SAMPLE_BITS;
   localparam int FB = spd_pkg::FRAC_BITS;
   localparam int AB = spd_pkg::ALPHA_BITS;

   logic                      in_valid_ff;
   spd_pkg::req_payload_type  in_item_ff;
   logic                      started_ff;
   logic                      started_in;
   logic signed [SW-1:0]      value_ff;
   logic signed [SW-1:0]      value_in;
   spd_pkg::smooth_type       smooth_ff;

   logic [AB-1:0]             alpha_clip;
   logic signed [AB:0]        alpha_ext;
   logic signed [SW-1:0]      target;
   logic signed [SW:0]        diff;
   logic signed [SW+AB+1:0]   product;
   logic signed [SW:0]        delta;
   logic signed [SW:0]        sum;

   // Capture the item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_item_ff <= req_item;
      end
   end

   // Exponential average: s += (alpha * ((x << 15) - s)) >>> 15
   always_comb begin
      alpha_clip = (alpha_q15 > spd_pkg::ALPHA_ONE) ? spd_pkg::ALPHA_ONE : alpha_q15;
      alpha_ext  = $signed({1'b0, alpha_clip});
      target     = {{(SW-SB-FB){in_item_ff.sample[SB-1]}}, in_item_ff.sample, {FB{1'b0}}};
      diff       = {target[SW-1], target} - {value_ff[SW-1], value_ff};
      product    = diff * alpha_ext;
      delta      = product[FB+SW:FB];
      sum        = {value_ff[SW-1], value_ff} + delta;
      value_in   = started_ff ? sum[SW-1:0] : target;
      started_in = !in_item_ff.last;
   end

   // Advance the average and hand the item on
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff      <= 1'b0;
         value_ff        <= '0;
         smooth_ff.valid <= 1'b0;
      end else if (advance) begin
         smooth_ff.valid <= in_valid_ff;
         if (in_valid_ff) begin
            started_ff <= started_in;
            value_ff   <= value_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         smooth_ff.first <= !started_ff;
         smooth_ff.last  <= in_item_ff.last;
         smooth_ff.value <= value_in;
      end
   end

   assign smooth = smooth_ff;

endmodule

### hdl/spd_detect.sv
`timescale 1ns / 1ps

module spd_detect (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  spd_pkg::smooth_type       smooth,
   input  spd_pkg::cfg_type          cfg,
   output logic                      rsp_valid,
   output spd_pkg::rsp_payload_type  rsp_item
);

   localparam int SW = spd_pkg::SMOOTH_BITS;
   localparam int SB = spd_pkg::SAMPLE_BITS;
   localparam int FB = spd_pkg::FRAC_BITS;
   localparam int IB = spd_pkg::INDEX_BITS;

   logic [IB-1:0]          count_ff;
   logic [IB-1:0]          count_in;
   logic [IB-1:0]          start_ff;
   logic [IB-1:0]          start_in;
   logic                   in_pulse_ff;
   logic                   in_pulse_in;
   logic                   prev_above_ff;
   logic signed [SW-1:0]   peak_ff;
   logic signed [SW-1:0]   peak_in;
   logic                   rsp_valid_ff;
   spd_pkg::rsp_payload_type rsp_item_ff;

   logic signed [SW-1:0]   floor_q;
   logic signed [SB+1:0]   need_sum;
   logic signed [SW:0]     need;
   logic                   above;
   logic                   open_pulse;
   logic                   close_pulse;
   logic                   grow_peak;
   logic [IB-1:0]          end_index;
   logic [IB-1:0]          width;
   logic                   qualified;
   logic                   emit;

   // Compare, open, close and track the peak
   always_comb begin
      floor_q  = {{(SW-SB-FB){cfg.floor_level[SB-1]}}, cfg.floor_level, {FB{1'b0}}};
      need_sum = {{2{cfg.floor_level[SB-1]}}, cfg.floor_level}
               + $signed({2'b00, cfg.amplitude_threshold});
      need     = {need_sum, {FB{1'b0}}};
      above    = smooth.value > floor_q;

      open_pulse  = !smooth.first && !in_pulse_ff && above && !prev_above_ff;
      close_pulse = !smooth.first && in_pulse_ff && !above;
      grow_peak   = !smooth.first && in_pulse_ff && above && (smooth.value > peak_ff);

      in_pulse_in = open_pulse ? 1'b1 : (close_pulse ? 1'b0 : in_pulse_ff);
      start_in    = open_pulse ? count_ff : start_ff;
      peak_in     = (open_pulse || grow_peak) ? smooth.value : peak_ff;
      count_in    = (count_ff == {IB{1'b1}}) ? count_ff : count_ff + IB'(1);

      // Falling crossing ends at this index, end of record at the length
      end_index = close_pulse ? count_ff : count_in;
      width     = (end_index >= start_in) ? end_index - start_in : '0;
      qualified = (width >= cfg.min_width) && (width <= cfg.max_width)
               && ($signed({peak_in[SW-1], peak_in}) >= need);
      emit      = smooth.valid && qualified
               && (close_pulse || (smooth.last && in_pulse_in));
   end

   // Update pulse state; clear it after the last item of a record
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         start_ff      <= '0;
         in_pulse_ff   <= 1'b0;
         prev_above_ff <= 1'b0;
         peak_ff       <= '0;
      end else if (advance && smooth.valid) begin
         if (smooth.last) begin
            count_ff      <= '0;
            start_ff      <= '0;
            in_pulse_ff   <= 1'b0;
            prev_above_ff <= 1'b0;
            peak_ff       <= '0;
         end else begin
            count_ff      <= count_in;
            start_ff      <= start_in;
            in_pulse_ff   <= in_pulse_in;
            prev_above_ff <= above;
            peak_ff       <= peak_in;
         end
      end
   end

   // Output register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff.start_index <= start_in;
         rsp_item_ff.end_index   <= end_index;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

### tb/tb_smoothed_pulse_detector_core.sv
`timescale 1ns / 1ps

module tb_smoothed_pulse_detector_core;

   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 92;
   localparam int SAMPLE_MAX   = 2 ** (spd_pkg::SAMPLE_BITS - 1) - 1;
   localparam int SAMPLE_MIN   = -(2 ** (spd_pkg::SAMPLE_BITS - 1));
   localparam int WIDTH_MAX    = 2 ** spd_pkg::INDEX_BITS - 1;
   localparam logic [spd_pkg::INDEX_BITS-1:0] INDEX_MAX = {spd_pkg::INDEX_BITS{1'b1}};

   typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   logic                               clock     = 1'b0;
   logic                               reset     = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   spd_pkg::req_payload_type           req_item  = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   spd_pkg::rsp_payload_type           rsp_item;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [spd_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [spd_pkg::CSR_DATA_BITS-1:0]  csr_data  = '0;

   // Detector copy: registers and record state
   spd_pkg::cfg_type               det_cfg;
   longint                         avg_q15;
   longint                         peak_q15;
   logic [spd_pkg::INDEX_BITS-1:0] record_count;
   logic [spd_pkg::INDEX_BITS-1:0] open_start;
   logic                           pulse_open;
   logic                           was_above;
   logic                           record_live;

   spd_pkg::rsp_payload_type pulse_expected[$];
   spd_pkg::req_payload_type sample_backlog[$];
   int unsigned     samples_queued = 0;
   int unsigned     samples_taken  = 0;
   int unsigned     fail_count     = 0;
   int              burst_left     = 0;
   int              gap_left       = 0;
   stall_style_type stall_style    = STALL_NONE;
   int              stall_span     = 0;

   smoothed_pulse_detector_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic void clear_record_state();
      avg_q15      = 0;
      peak_q15     = 0;
      record_count = '0;
      open_start   = '0;
      pulse_open   = 1'b0;
      was_above    = 1'b0;
      record_live  = 1'b0;
   endfunction

   // Accept a pulse only inside the width window and tall enough above the floor
   function automatic logic pulse_passes(input logic [spd_pkg::INDEX_BITS-1:0] first,
                                         input logic [spd_pkg::INDEX_BITS-1:0] stop);
      logic [spd_pkg::INDEX_BITS-1:0] width;
      longint                         need;
      width = (stop >= first) ? stop - first : '0;
      if (width < det_cfg.min_width || width > det_cfg.max_width)
         return 1'b0;
      need = (longint'($signed(det_cfg.floor_level))
              + longint'(det_cfg.amplitude_threshold)) <<< spd_pkg::FRAC_BITS;
      return peak_q15 >= need;
   endfunction

   task automatic expect_pulse(input logic [spd_pkg::INDEX_BITS-1:0] first,
                               input logic [spd_pkg::INDEX_BITS-1:0] stop);
      spd_pkg::rsp_payload_type hit;
      hit.start_index = first;
      hit.end_index   = stop;
      pulse_expected.insert(pulse_expected.size(), hit);
   endtask

   // Advance the detector copy by one sample, queue any pulse it closes
   task automatic advance_detector(input spd_pkg::req_payload_type it);
      longint                         target;
      longint                         floor_q15;
      longint                         weight;
      logic [spd_pkg::INDEX_BITS-1:0] idx;
      logic                           above;
      target    = longint'($signed(it.sample)) <<< spd_pkg::FRAC_BITS;
      floor_q15 = longint'($signed(det_cfg.floor_level)) <<< spd_pkg::FRAC_BITS;
      weight    = (det_cfg.alpha_q15 > spd_pkg::ALPHA_ONE) ? longint'(spd_pkg::ALPHA_ONE)
                                                           : longint'(det_cfg.alpha_q15);
      idx = record_count;
      if (!record_live) begin
         // load the first sample of a record as is; it never opens a pulse
         avg_q15     = target;
         record_live = 1'b1;
         above       = avg_q15 > floor_q15;
      end else begin
         avg_q15 = avg_q15 + ((weight * (target - avg_q15)) >>> spd_pkg::FRAC_BITS);
         above   = avg_q15 > floor_q15;
         if (!pulse_open && above && !was_above) begin
            open_start = idx;
            pulse_open = 1'b1;
            peak_q15   = avg_q15;
         end else if (pulse_open && !above) begin
            if (pulse_passes(open_start, idx))
               expect_pulse(open_start, idx);
            pulse_open = 1'b0;
         end else if (pulse_open && avg_q15 > peak_q15) begin
            peak_q15 = avg_q15;
         end
      end
      was_above    = above;
      record_count = (idx == INDEX_MAX) ? idx : idx + 1'b1;
      // close an open pulse at the record end and restart
      if (it.last) begin
         if (pulse_open && pulse_passes(open_start, record_count))
            expect_pulse(open_start, record_count);
         clear_record_state();
      end
   endtask

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("[%0t] %s", $realtime, msg);
   endtask

   // Feed samples in bursts with gaps; hold an item while it is stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_detector(req_item);
            samples_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sample_backlog.size() > 0) begin
               req_item  <= sample_backlog.pop_front();
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                  burst_left = $urandom_range(1, 40);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Stall the result side in changing styles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_span <= 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
            stall_span  = $urandom_range(16, 160);
         end
         stall_span--;
         case (stall_style)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_COIN:  rsp_stall <= 1'($urandom_range(0, 1));
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((stall_span % 6) < 2);
         endcase
      end
   end

   // Check each taken pulse against the oldest expected one
   always @(posedge clock) begin
      spd_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pulse_expected.size() == 0) begin
            note_failure($sformatf("unexpected pulse start=%0d end=%0d",
                                   rsp_item.start_index, rsp_item.end_index));
         end else begin
            want = pulse_expected.pop_front();
            if (want.start_index != rsp_item.start_index ||
                want.end_index != rsp_item.end_index)
               note_failure($sformatf({"pulse mismatch: expected start=%0d end=%0d, ",
                                       "got start=%0d end=%0d"},
                                      want.start_index, want.end_index,
                                      rsp_item.start_index, rsp_item.end_index));
         end
      end
   end

   task automatic write_register(input spd_pkg::csr_index_type idx,
                                 input logic [spd_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         spd_pkg::CSR_ALPHA:
            det_cfg.alpha_q15           = value[spd_pkg::ALPHA_BITS-1:0];
         spd_pkg::CSR_FLOOR:
            det_cfg.floor_level         = value[spd_pkg::SAMPLE_BITS-1:0];
         spd_pkg::CSR_AMPLITUDE:
            det_cfg.amplitude_threshold = value[spd_pkg::SAMPLE_BITS-1:0];
         spd_pkg::CSR_MIN_WIDTH:
            det_cfg.min_width           = value[spd_pkg::INDEX_BITS-1:0];
         spd_pkg::CSR_MAX_WIDTH:
            det_cfg.max_width           = value[spd_pkg::INDEX_BITS-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_detector(input int alpha, input int floor_value, input int amp,
                               input int min_w, input int max_w);
      write_register(spd_pkg::CSR_ALPHA, alpha[spd_pkg::CSR_DATA_BITS-1:0]);
      write_register(spd_pkg::CSR_FLOOR, floor_value[spd_pkg::CSR_DATA_BITS-1:0]);
      write_register(spd_pkg::CSR_AMPLITUDE, amp[spd_pkg::CSR_DATA_BITS-1:0]);
      write_register(spd_pkg::CSR_MIN_WIDTH, min_w[spd_pkg::CSR_DATA_BITS-1:0]);
      write_register(spd_pkg::CSR_MAX_WIDTH, max_w[spd_pkg::CSR_DATA_BITS-1:0]);
   endtask

   task automatic queue_sample(input int value, input logic last);
      spd_pkg::req_payload_type it;
      if (value > SAMPLE_MAX)
         value = SAMPLE_MAX;
      else if (value < SAMPLE_MIN)
         value = SAMPLE_MIN;
      it.sample = value[spd_pkg::SAMPLE_BITS-1:0];
      it.last   = last;
      sample_backlog.insert(sample_backlog.size(), it);
      samples_queued++;
   endtask

   // Build one record of alternating runs above and below the floor
   task automatic queue_record(input int len);
      int   fl;
      int   level;
      int   value;
      int   run_left;
      logic high;
      fl       = int'(det_cfg.floor_level);
      high     = 1'($urandom_range(0, 1));
      run_left = 0;
      level    = fl;
      for (int n = 0; n < len; n++) begin
         if (run_left == 0) begin
            high     = !high;
            run_left = $urandom_range(1, 10);
            level    = high ? fl + int'($urandom_range(1, 6000))
                            : fl - int'($urandom_range(0, 6000));
         end
         run_left--;
         case ($urandom_range(0, 15))
            0:       value = int'($urandom_range(0, 65535)) + SAMPLE_MIN;
            1:       value = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            default: value = level + int'($urandom_range(0, 400)) - 200;
         endcase
         queue_sample(value, n == len - 1);
      end
   endtask

   // Wait until every sample is taken and every pulse is in, then drain
   task automatic wait_idle();
      do @(posedge clock);
      while (samples_taken != samples_queued || pulse_expected.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(input int items);
      int count;
      int len;
      count = 0;
      while (count < items) begin
         len = ($urandom_range(0, 11) == 0) ? 1 : $urandom_range(2, 40);
         queue_record(len);
         count += len;
      end
      wait_idle();
   endtask

   initial begin
      det_cfg.alpha_q15           = spd_pkg::ALPHA_RESET;
      det_cfg.floor_level         = '0;
      det_cfg.amplitude_threshold = '0;
      det_cfg.min_width           = '0;
      det_cfg.max_width           = spd_pkg::MAX_WIDTH_RESET;
      clear_record_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed records at reset-like settings
      set_detector(int'(spd_pkg::ALPHA_RESET), 0, 0, 0, WIDTH_MAX);
      // one-sample record
      queue_sample(0, 1'b1);
      // extremes; first sample above never opens, pulse closed by last
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b1);
      // pulse closed by a falling crossing
      queue_sample(-100, 1'b0);
      queue_sample(5000, 1'b0);
      queue_sample(4000, 1'b0);
      queue_sample(-5000, 1'b0);
      queue_sample(-5000, 1'b0);
      queue_sample(0, 1'b1);
      // width-one pulse opened and closed by last
      queue_sample(0, 1'b0);
      queue_sample(1, 1'b1);
      wait_idle();

      // Sweep fixed settings, extremes among them
      for (int k = 0; k < 7; k++) begin
         case (k)
            0: set_detector(int'(spd_pkg::ALPHA_ONE), 0, 0, 0, WIDTH_MAX);
            1: set_detector(65535, SAMPLE_MIN, 0, 1, 3);
            2: set_detector(0, SAMPLE_MAX, 65535, 0, WIDTH_MAX);
            3: set_detector(16384, -1000, 2000, 2, 10);
            4: set_detector(3000, 500, 100, 5, 2);
            5: set_detector(20000, 0, 0, WIDTH_MAX, WIDTH_MAX);
            default: set_detector(int'(spd_pkg::ALPHA_RESET), 0, 0, 0, 0);
         endcase
         run_random_phase(PHASE_ITEMS);
      end

      // Random settings
      for (int p = 0; p < 4; p++) begin
         set_detector(($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 65535))
                                                  : int'($urandom_range(2000, 32768)),
                      int'($urandom_range(0, 8000)) - 4000,
                      $urandom_range(0, 3000),
                      $urandom_range(0, 4),
                      $urandom_range(4, 40));
         run_random_phase(PHASE_ITEMS);
      end

      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Guard against a hang
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

### files.f
hdl/spd_pkg.sv
hdl/spd_csr.sv
hdl/spd_smooth.sv
hdl/spd_detect.sv
hdl/smoothed_pulse_detector_core.sv
tb/tb_smoothed_pulse_detector_core.sv
